// ----- rtl/rvpi_pkg.sv -----
// Shared types and constants for the ramped velocity pose integrator.
package rvpi_pkg;

    localparam int unsigned CORDIC_MAX = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] REG_VEL_X = 3'd0;
    localparam logic [2:0] REG_VEL_Y = 3'd1;
    localparam logic [2:0] REG_TURN  = 3'd2;
    localparam logic [2:0] REG_STEP  = 3'd3;
    localparam logic [2:0] REG_RAMP  = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_CORD  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_ACC   = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

    function automatic logic [31:0] atan_q32(input logic [4:0] k);
        logic [31:0] r;
        begin
            unique case (k)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/rvpi_div.sv -----
// Shift-subtract divider for the ramp scale, one quotient bit per cycle.
module rvpi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic [31:0] o_quo,
    output rvpi_pkg::t_div_ctl o_ctl
);
    logic [31:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [16:0] w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[15:0], r_quo[31]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem = w_trial - {1'b0, i_den};
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_quo = r_quo;
    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};

    ap_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 6'd0) else $error("divider count empty while busy");
    ap_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    ap_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider failed to start");
endmodule

// ----- rtl/ramped_velocity_pose_integrator.sv -----
// Top level: pose integrator with ramp divider, one CORDIC and one shared multiplier.
// A step word passes through three ramp divisions, the CORDIC (one iteration per cycle),
// seven multiplies on the shared multiplier, the pose update and the output register.
// A load word sets pose and clears the step count in idle. Step words are taken one at
// a time, only in idle; a held result blocks the next step word until it leaves. Reset
// (i_rst_n low, synchronous) clears pose, step count and config to defaults.
module ramped_velocity_pose_integrator #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // start_x, start_y, start_heading
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata   // ref_x, ref_y, ref_heading, sample_index
);
    localparam int ITERS = (ANGLE_BITS < int'(rvpi_pkg::CORDIC_MAX)) ? ANGLE_BITS
                                                                     : int'(rvpi_pkg::CORDIC_MAX);
    localparam int SH = 30 - ANGLE_BITS;
    localparam int DSH = 12 + ANGLE_BITS;
    localparam int TW = ANGLE_BITS + 3;
    localparam int AW = ANGLE_BITS + 18;
    localparam int MW = (TW > 17) ? TW : 17;

    logic signed [15:0] r_vx_cfg, r_vy_cfg, r_w_cfg;
    logic [15:0] r_step_t, r_ramp_len;
    logic signed [31:0] r_px, r_py;
    logic [15:0] r_hd, r_cnt;
    rvpi_pkg::t_state r_st, n_st;
    logic [1:0] r_sel;
    logic [4:0] r_k;
    logic [2:0] r_m;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic r_flip;
    logic signed [16:0] r_vx, r_vy, r_w;
    logic signed [TW-1:0] r_c, r_s;
    logic signed [63:0] r_prod, r_ax, r_ay;
    logic r_ovalid;
    logic [95:0] r_odata;
    logic r_dstart;

    logic signed [15:0] w_v;
    logic [15:0] w_mag;
    logic [31:0] w_quo;
    rvpi_pkg::t_div_ctl w_dctl;
    logic signed [16:0] w_vr;
    logic signed [33:0] w_z0;
    logic signed [AW-1:0] w_ma;
    logic signed [MW-1:0] w_mb;
    logic w_dgo;

    assign o_cfg_ready = (r_st == rvpi_pkg::S_IDLE);
    always_comb begin
        unique case (r_sel)
            2'd0: w_v = r_vx_cfg;
            2'd1: w_v = r_vy_cfg;
            default: w_v = r_w_cfg;
        endcase
    end
    assign w_mag = w_v[15] ? 16'(-w_v) : w_v;

    rvpi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(32'(w_mag) * 32'(r_cnt)), .i_den(r_ramp_len),
        .o_quo(w_quo), .o_ctl(w_dctl)
    );
    assign w_vr = w_v[15] ? -$signed({1'b0, w_quo[15:0]}) : $signed({1'b0, w_quo[15:0]});

    assign s_axis_tready = (r_st == rvpi_pkg::S_IDLE) && !i_cfg_valid
                           && (!r_ovalid || m_axis_tready || s_axis_tuser == rvpi_pkg::CMD_LOAD);

    assign w_dgo = ((r_st == rvpi_pkg::S_IDLE) && s_axis_tvalid && s_axis_tready
                    && s_axis_tuser == rvpi_pkg::CMD_STEP)
                   || ((r_st == rvpi_pkg::S_DIV) && w_dctl.done && r_sel != 2'd2);

    always_comb begin
        w_z0 = {r_hd[15], r_hd[15], r_hd, 16'd0};
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_m)
            3'd0: begin w_ma = AW'(r_vx); w_mb = MW'(r_c); end
            3'd1: begin w_ma = AW'(r_vy); w_mb = MW'(r_s); end
            3'd2: begin w_ma = AW'(r_vx); w_mb = MW'(r_s); end
            3'd3: begin w_ma = AW'(r_vy); w_mb = MW'(r_c); end
            3'd4: begin w_ma = AW'(r_ax); w_mb = MW'($signed({1'b0, r_step_t})); end
            3'd5: begin w_ma = AW'(r_ay); w_mb = MW'($signed({1'b0, r_step_t})); end
            default: begin w_ma = AW'(r_w); w_mb = MW'($signed({1'b0, r_step_t})); end
        endcase
    end

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [63:0] d);
        logic signed [64:0] t;
        begin
            t = 65'(a) + 65'(d);
            if (t > 65'sd2147483647) return 32'h7fffffff;
            else if (t < -65'sd2147483648) return 32'h80000000;
            else return t[31:0];
        end
    endfunction

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            rvpi_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tready &&
                                  s_axis_tuser == rvpi_pkg::CMD_STEP) n_st = rvpi_pkg::S_DIV;
            rvpi_pkg::S_DIV:  if (w_dctl.done && r_sel == 2'd2) n_st = rvpi_pkg::S_CORD;
            rvpi_pkg::S_CORD: if (r_k == 5'(ITERS)) n_st = rvpi_pkg::S_MUL;
            rvpi_pkg::S_MUL:  n_st = rvpi_pkg::S_ACC;
            rvpi_pkg::S_ACC:  if (r_m == 3'd6) n_st = rvpi_pkg::S_UPD;
                              else n_st = rvpi_pkg::S_MUL;
            rvpi_pkg::S_UPD:  n_st = rvpi_pkg::S_OUT;
            rvpi_pkg::S_OUT:  n_st = rvpi_pkg::S_IDLE;
            default: n_st = rvpi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rvpi_pkg::S_IDLE;
            r_vx_cfg <= '0; r_vy_cfg <= '0; r_w_cfg <= '0;
            r_step_t <= 16'd6554; r_ramp_len <= '0;
            r_px <= '0; r_py <= '0; r_hd <= '0; r_cnt <= '0;
            r_ovalid <= 1'b0; r_dstart <= 1'b0;
            r_sel <= '0; r_k <= '0; r_m <= '0;
        end else begin
            r_st <= n_st;
            r_dstart <= w_dgo;
            r_ovalid <= (r_st == rvpi_pkg::S_OUT) || (r_ovalid && !m_axis_tready);
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rvpi_pkg::REG_VEL_X: r_vx_cfg <= i_cfg_data;
                    rvpi_pkg::REG_VEL_Y: r_vy_cfg <= i_cfg_data;
                    rvpi_pkg::REG_TURN:  r_w_cfg  <= i_cfg_data;
                    rvpi_pkg::REG_STEP:  r_step_t <= i_cfg_data;
                    rvpi_pkg::REG_RAMP:  r_ramp_len <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                rvpi_pkg::S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    if (s_axis_tuser == rvpi_pkg::CMD_LOAD) begin
                        r_px <= s_axis_tdata[31:0];
                        r_py <= s_axis_tdata[63:32];
                        r_hd <= s_axis_tdata[79:64];
                        r_cnt <= '0;
                    end else begin
                        r_odata <= {r_cnt, r_hd, r_py, r_px};
                        r_sel <= 2'd0;
                    end
                end
                rvpi_pkg::S_DIV: if (w_dctl.done) begin
                    if (r_ramp_len == 16'd0 || r_cnt >= r_ramp_len) begin
                        unique case (r_sel)
                            2'd0: r_vx <= 17'(w_v);
                            2'd1: r_vy <= 17'(w_v);
                            default: r_w <= 17'(w_v);
                        endcase
                    end else begin
                        unique case (r_sel)
                            2'd0: r_vx <= w_vr;
                            2'd1: r_vy <= w_vr;
                            default: r_w <= w_vr;
                        endcase
                    end
                    if (r_sel != 2'd2) begin
                        r_sel <= r_sel + 2'd1;
                    end else begin
                        r_k <= '0;
                        r_cx <= rvpi_pkg::CORDIC_GAIN;
                        r_cy <= '0;
                        if (w_z0 > 34'sd1073741824) begin
                            r_cz <= w_z0 - 34'sd2147483648; r_flip <= 1'b1;
                        end else if (w_z0 < -34'sd1073741824) begin
                            r_cz <= w_z0 + 34'sd2147483648; r_flip <= 1'b1;
                        end else begin
                            r_cz <= w_z0; r_flip <= 1'b0;
                        end
                    end
                end
                rvpi_pkg::S_CORD: begin
                    if (r_k != 5'(ITERS)) begin
                        if (!r_cz[33]) begin
                            r_cx <= r_cx - (r_cy >>> r_k);
                            r_cy <= r_cy + (r_cx >>> r_k);
                            r_cz <= r_cz - $signed({2'b0, rvpi_pkg::atan_q32(r_k)});
                        end else begin
                            r_cx <= r_cx + (r_cy >>> r_k);
                            r_cy <= r_cy - (r_cx >>> r_k);
                            r_cz <= r_cz + $signed({2'b0, rvpi_pkg::atan_q32(r_k)});
                        end
                        r_k <= r_k + 5'd1;
                    end else begin
                        r_c <= r_flip ? -TW'((r_cx + (34'sd1 <<< (SH-1))) >>> SH)
                                      :  TW'((r_cx + (34'sd1 <<< (SH-1))) >>> SH);
                        r_s <= r_flip ? -TW'((r_cy + (34'sd1 <<< (SH-1))) >>> SH)
                                      :  TW'((r_cy + (34'sd1 <<< (SH-1))) >>> SH);
                        r_m <= '0;
                    end
                end
                rvpi_pkg::S_MUL: r_prod <= w_ma * w_mb;
                rvpi_pkg::S_ACC: begin
                    unique case (r_m)
                        3'd0: r_ax <= r_prod;
                        3'd1: r_ax <= r_ax - r_prod;
                        3'd2: r_ay <= r_prod;
                        3'd3: r_ay <= r_ay + r_prod;
                        3'd4: r_ax <= (r_prod + (64'sd1 <<< (DSH-1))) >>> DSH;
                        3'd5: r_ay <= (r_prod + (64'sd1 <<< (DSH-1))) >>> DSH;
                        default: r_prod <= (r_prod + 64'sd32768) >>> 16;
                    endcase
                    r_m <= r_m + 3'd1;
                end
                rvpi_pkg::S_UPD: begin
                    r_px <= sat_add(r_px, r_ax);
                    r_py <= sat_add(r_py, r_ay);
                    r_hd <= r_hd + r_prod[15:0];
                    if (r_cnt != 16'hffff) r_cnt <= r_cnt + 16'd1;
                end
                rvpi_pkg::S_OUT: ;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    ap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != rvpi_pkg::S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    ap_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == rvpi_pkg::S_OUT) |=> r_ovalid) else $error("result lost");
    ap_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != rvpi_pkg::S_IDLE) |-> !o_cfg_ready) else $error("config while busy");
endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the ramped velocity pose integrator.
`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_CYCLES = 200;
    localparam int ABITS = 16;
    localparam logic [2:0] REG_SPARE_LO = rvpi_pkg::REG_RAMP + 3'd1;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    class pose_scoreboard;
        logic signed [15:0] vel_x, vel_y, turn;
        logic [15:0] step_t, ramp_len;
        logic signed [31:0] px, py;
        logic [15:0] hd, cnt;
        logic [95:0] pending_poses[$];
        int errors;
        int steps_seen;
        int loads_seen;

        function new();
            vel_x = 0; vel_y = 0; turn = 0; step_t = 16'd6554; ramp_len = 0;
            px = 0; py = 0; hd = 0; cnt = 0; errors = 0; steps_seen = 0; loads_seen = 0;
        endfunction

        function void note_config(logic [2:0] idx, logic [15:0] val);
            case (idx)
                rvpi_pkg::REG_VEL_X: vel_x = val;
                rvpi_pkg::REG_VEL_Y: vel_y = val;
                rvpi_pkg::REG_TURN:  turn = val;
                rvpi_pkg::REG_STEP:  step_t = val;
                rvpi_pkg::REG_RAMP:  ramp_len = val;
                default: ;
            endcase
        endfunction

        function longint ramp_rate(longint v, longint i);
            longint mag;
            if (ramp_len == 0 || i >= ramp_len) return v;
            mag = ((v < 0) ? -v : v) * i / ramp_len;
            return (v < 0) ? -mag : mag;
        endfunction

        function longint round_shift(longint v, int k);
            return (v + (longint'(1) << (k - 1))) >>> k;
        endfunction

        function void sin_cos(logic [15:0] h, output longint s, output longint c);
            longint z, x, y, nx;
            bit flip;
            z = longint'(h) * 65536;
            x = 652032874;
            y = 0;
            flip = 0;
            if (z >= 64'sd2147483648) z -= 64'sd4294967296;
            if (z > 64'sd1073741824) begin
                z -= 64'sd2147483648; flip = 1;
            end else if (z < -64'sd1073741824) begin
                z += 64'sd2147483648; flip = 1;
            end
            for (int k = 0; k < ABITS; k++) begin
                if (z >= 0) begin
                    nx = x - (y >>> k); y = y + (x >>> k);
                    z -= longint'(rvpi_pkg::atan_q32(5'(k)));
                end else begin
                    nx = x + (y >>> k); y = y - (x >>> k);
                    z += longint'(rvpi_pkg::atan_q32(5'(k)));
                end
                x = nx;
            end
            x = round_shift(x, 30 - ABITS);
            y = round_shift(y, 30 - ABITS);
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic signed [31:0] sat_add(logic signed [31:0] a, longint d);
            longint r;
            r = longint'(a) + d;
            if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (r < -64'sd2147483648) return 32'sh80000000;
            return r[31:0];
        endfunction

        function void note_word(logic cmd, logic [79:0] data);
            longint vx, vy, w, s, c, dx, dy, dh;
            if (cmd == rvpi_pkg::CMD_LOAD) begin
                px = data[31:0]; py = data[63:32]; hd = data[79:64]; cnt = 0;
                loads_seen++;
                return;
            end
            steps_seen++;
            pending_poses.push_back({cnt, hd, py, px});
            vx = ramp_rate(vel_x, cnt);
            vy = ramp_rate(vel_y, cnt);
            w = ramp_rate(turn, cnt);
            sin_cos(hd, s, c);
            dx = round_shift((vx * c - vy * s) * longint'(step_t), 12 + ABITS);
            dy = round_shift((vx * s + vy * c) * longint'(step_t), 12 + ABITS);
            dh = round_shift(w * longint'(step_t), 16);
            px = sat_add(px, dx);
            py = sat_add(py, dy);
            hd = hd + dh[15:0];
            if (cnt != 16'hFFFF) cnt++;
        endfunction

        function void check_result(logic [95:0] got);
            logic [95:0] want;
            if (pending_poses.size() == 0) begin
                $error("unexpected pose word %h", got);
                errors++;
                return;
            end
            want = pending_poses.pop_front();
            if (got[31:0] !== want[31:0]) begin
                $error("ref_x expected %0d got %0d", $signed(want[31:0]), $signed(got[31:0]));
                errors++;
            end
            if (got[63:32] !== want[63:32]) begin
                $error("ref_y expected %0d got %0d", $signed(want[63:32]),
                       $signed(got[63:32]));
                errors++;
            end
            if (got[79:64] !== want[79:64]) begin
                $error("ref_heading expected %0d got %0d", want[79:64], got[79:64]);
                errors++;
            end
            if (got[95:80] !== want[95:80]) begin
                $error("sample_index expected %0d got %0d", want[95:80], got[95:80]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;

    pose_scoreboard sb;
    int rx_stall_pct;
    int rx_hold;
    int burst_left;
    int cfg_writes;

    ramped_velocity_pose_integrator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, val);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(logic cmd, logic [79:0] data);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(cmd, data);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_load(logic [31:0] x, logic [31:0] y, logic [15:0] h);
        send_word(rvpi_pkg::CMD_LOAD, {h, y, x});
    endtask

    task automatic send_step();
        send_word(rvpi_pkg::CMD_STEP, 80'({$urandom(), $urandom(), $urandom()} >> 16));
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h7FFFFFFF - $urandom_range(0, 1 << 20);
            1: return 32'h80000000 + $urandom_range(0, 1 << 20);
            2: return $urandom_range(0, 1 << 22) - (1 << 21);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_config();
        logic [15:0] st;
        write_reg(rvpi_pkg::REG_VEL_X, pick16(16'h8000, 16'h7FFF));
        write_reg(rvpi_pkg::REG_VEL_Y, pick16(16'h8000, 16'h7FFF));
        write_reg(rvpi_pkg::REG_TURN, pick16(16'h8000, 16'h7FFF));
        case ($urandom_range(0, 7))
            0: st = 16'd0;
            1: st = 16'd1;
            2: st = 16'hFFFF;
            default: st = 16'($urandom());
        endcase
        write_reg(rvpi_pkg::REG_STEP, st);
        case ($urandom_range(0, 5))
            0: write_reg(rvpi_pkg::REG_RAMP, 16'd0);
            1: write_reg(rvpi_pkg::REG_RAMP, 16'hFFFF);
            default: write_reg(rvpi_pkg::REG_RAMP, 16'($urandom_range(1, 30)));
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom()));
    endtask

    initial begin
        #6000000;
        $display("ramped_velocity_pose_integrator verification failed");
        $finish;
    end

    initial begin
        int sent;
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = rvpi_pkg::CMD_LOAD;
        m_axis_tready = 1'b0;
        rx_stall_pct = 0;
        rx_hold = 0;
        burst_left = 1;
        cfg_writes = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults, extremes, no ramp, zero step time, saturation
        send_step();
        send_step();
        drain();
        write_reg(rvpi_pkg::REG_VEL_X, 16'h7FFF);
        write_reg(rvpi_pkg::REG_VEL_Y, 16'h8000);
        write_reg(rvpi_pkg::REG_TURN, 16'h7FFF);
        write_reg(rvpi_pkg::REG_STEP, 16'hFFFF);
        write_reg(rvpi_pkg::REG_RAMP, 16'd0);
        write_reg(REG_SPARE_LO, 16'h1234);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        send_load(32'h7FFFFF00, 32'h80000100, 16'h0000);
        repeat (4) send_step();
        send_load(32'h80000000, 32'h7FFFFFFF, 16'h8000);
        repeat (4) send_step();
        send_load(32'h0, 32'h0, 16'hFFFF);
        repeat (3) send_step();
        drain();
        write_reg(rvpi_pkg::REG_STEP, 16'd0);
        write_reg(rvpi_pkg::REG_RAMP, 16'd3);
        send_load(32'h00010000, 32'hFFFF0000, 16'h4000);
        repeat (3) send_step();
        drain();
        write_reg(rvpi_pkg::REG_STEP, 16'd1);
        write_reg(rvpi_pkg::REG_RAMP, 16'hFFFF);
        write_reg(rvpi_pkg::REG_TURN, 16'h8000);
        send_load(32'h0, 32'h0, 16'hC000);
        repeat (2) send_step();
        drain();

        sent = 0;
        for (int phase = 0; sent < 870; phase++) begin
            random_config();
            rx_stall_pct = (phase % 4 == 0) ? 0 : $urandom_range(5, 70);
            if (phase == 2) rx_hold = 600;
            send_load(pick32(), pick32(), 16'($urandom()));
            sent++;
            for (int n = $urandom_range(20, 60); n > 0; n--) begin
                if ($urandom_range(0, 19) == 0) send_load(pick32(), pick32(), 16'($urandom()));
                else send_step();
                sent++;
            end
            drain();
        end

        drain();
        $display("covered %0d step words, %0d load words, %0d register writes",
                 sb.steps_seen, sb.loads_seen, cfg_writes);
        if (sb.errors == 0) begin
            $display("ramped_velocity_pose_integrator verification clean");
        end else begin
            $display("ramped_velocity_pose_integrator verification failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/rvpi_pkg.sv
rtl/rvpi_div.sv
rtl/ramped_velocity_pose_integrator.sv
dv/tb.sv
